[hw/rtl/lsm_pkg.sv]
// Shared types and constants for the line substring matcher.
package lsm_pkg;

   // Pattern storage is fixed at two 64-bit words.
   localparam int PAT_BYTES  = 16;
   localparam int LEN_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int LINE_IDX_W = 16;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] NUL_CHAR     = 8'h00;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] UPPER_FIRST  = 8'h41;
   localparam logic [7:0] UPPER_LAST   = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2,
      CSR_IGNORE_CASE    = 2'd3
   } csr_index_type;

   // One classified text byte, as handed from front to back.
   typedef struct packed {
      logic [PAT_BYTES-1:0] eq;         // byte equals pattern byte i (within length)
      logic [PAT_BYTES-1:0] mask;       // bits below the active length
      logic [PAT_BYTES-1:0] top;        // one-hot at active length - 1
      logic                 empty;      // active pattern is empty
      logic                 is_nul;
      logic                 is_newline;
      logic                 is_last;
   } lsm_item_type;

endpackage

[hw/rtl/lsm_channels.sv]
// Valid/ready channel interfaces for text requests, line results and register writes.
interface lsm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface lsm_rsp_if;
   import lsm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  line_hit;
   logic [LINE_IDX_W-1:0] line_index;
   logic                  any_hit;
   logic                  final_line;

   modport source (output valid, output line_hit, output line_index, output any_hit,
                   output final_line, input ready);
   modport sink   (input valid, input line_hit, input line_index, input any_hit,
                   input final_line, output ready);
endinterface

interface lsm_csr_if;
   import lsm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/line_substring_matcher_unit.sv]
// Top level of the line substring matcher.
//
// Text bytes enter on req_bus (text_byte, end_of_text), one request per byte.
// Each line that ends (newline byte, LINE_BUF-1 bytes, or end_of_text) gives one
// result on rsp_bus: line_hit, line_index, any_hit and final_line.
// csr_bus writes the pattern words, pattern length and case folding; it is
// always ready and should be used only while no text is in flight.
// Throughput: one byte per cycle while rsp_bus does not stall, limited by the
// shift-and update in the back end. The byte that ends a line enters the queue
// at the edge that accepts its request; the back end loads the result register
// when it takes that byte from the queue, and the line result is then valid.
// When rsp_bus stalls, the result register holds, the two-entry queue fills
// and req_bus.ready drops; bytes that end no line keep flowing while the
// result register is empty or being drained.
// Reset clears the configuration registers, the queue and all line and match state; the
// first byte after reset starts line zero of a new text.
module line_substring_matcher_unit #(
   parameter int PATTERN_MAX = 16,
   parameter int LINE_BUF    = 1024
) (
   input  logic     clock,
   input  logic     reset,
   lsm_req_if.sink  req_bus,
   lsm_rsp_if.source rsp_bus,
   lsm_csr_if.sink  csr_bus
);
   import lsm_pkg::*;

   localparam int VEC_W = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;

   lsm_item_type front_item, back_item;
   logic         front_valid, front_ready;
   logic         back_valid, back_ready;

   lsm_front #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .item       (front_item),
      .item_valid (front_valid),
      .item_ready (front_ready)
   );

   lsm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (front_item),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_item  (back_item),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   lsm_back #(
      .VEC_W    (VEC_W),
      .LINE_BUF (LINE_BUF)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (back_item),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

[hw/rtl/lsm_front.sv]
// Front end: configuration registers and per-byte classification against the pattern.
module lsm_front #(
   parameter int PATTERN_MAX = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   lsm_req_if.sink               req_bus,
   lsm_csr_if.sink               csr_bus,
   output lsm_pkg::lsm_item_type item,
   output logic                  item_valid,
   input  logic                  item_ready
);
   import lsm_pkg::*;

   localparam int VEC_W = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;

   logic [CSR_DATA_W-1:0]  pattern_low_ff, pattern_low_in;
   logic [CSR_DATA_W-1:0]  pattern_high_ff, pattern_high_in;
   logic [LEN_W-1:0]       pattern_length_ff, pattern_length_in;
   logic                   ignore_case_ff, ignore_case_in;

   logic [PAT_BYTES*8-1:0] pat_all;
   logic [LEN_W-1:0]       cap_len;
   logic [LEN_W-1:0]       active_len;
   logic [7:0]             text_fold;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
      logic [7:0] r;
      r = c;
      if (ic && (c inside {[UPPER_FIRST:UPPER_LAST]})) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   // Register writes
   assign csr_bus.ready = 1'b1;

   always_comb begin
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      pattern_length_in = pattern_length_ff;
      ignore_case_in    = ignore_case_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_PATTERN_LOW:    pattern_low_in    = csr_bus.data;
            CSR_PATTERN_HIGH:   pattern_high_in   = csr_bus.data;
            CSR_PATTERN_LENGTH: pattern_length_in = csr_bus.data[LEN_W-1:0];
            CSR_IGNORE_CASE:    ignore_case_in    = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
         ignore_case_ff    <= 1'b0;
      end else begin
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         pattern_length_ff <= pattern_length_in;
         ignore_case_ff    <= ignore_case_in;
      end
   end

   // Active length: saturate, then stop at the first zero pattern byte
   assign pat_all = {pattern_high_ff, pattern_low_ff};
   assign cap_len = (pattern_length_ff > LEN_W'(VEC_W)) ? LEN_W'(VEC_W) : pattern_length_ff;

   always_comb begin
      active_len = cap_len;
      for (int i = PAT_BYTES - 1; i >= 0; i--) begin
         if ((LEN_W'(i) < cap_len) && (pat_all[8*i +: 8] == NUL_CHAR)) begin
            active_len = LEN_W'(i);
         end
      end
   end

   // Classify the incoming byte
   assign text_fold = fold_byte(req_bus.text_byte, ignore_case_ff);

   always_comb begin
      for (int i = 0; i < PAT_BYTES; i++) begin
         item.mask[i] = (LEN_W'(i) < active_len);
         item.top[i]  = (LEN_W'(i + 1) == active_len);
         item.eq[i]   = (LEN_W'(i) < active_len) &&
                        (fold_byte(pat_all[8*i +: 8], ignore_case_ff) == text_fold);
      end
      item.empty      = (active_len == '0);
      item.is_nul     = (req_bus.text_byte == NUL_CHAR);
      item.is_newline = (req_bus.text_byte == NEWLINE_CHAR);
      item.is_last    = req_bus.end_of_text;
   end

   assign item_valid    = req_bus.valid;
   assign req_bus.ready = item_ready;

endmodule

[hw/rtl/lsm_queue.sv]
// Short FIFO of classified bytes between front and back.
module lsm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  lsm_pkg::lsm_item_type in_item,
   input  logic                  in_valid,
   output logic                  in_ready,
   output lsm_pkg::lsm_item_type out_item,
   output logic                  out_valid,
   input  logic                  out_ready
);
   import lsm_pkg::*;

   lsm_item_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[hw/rtl/lsm_back.sv]
// Back end: shift-and match state, line tracking and the result register.
module lsm_back #(
   parameter int VEC_W    = 16,
   parameter int LINE_BUF = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lsm_pkg::lsm_item_type item,
   input  logic                  item_valid,
   output logic                  item_ready,
   lsm_rsp_if.source             rsp_bus
);
   import lsm_pkg::*;

   localparam int CNT_W = $clog2(LINE_BUF);

   logic [VEC_W-1:0]      match_vector_ff, match_vector_in;
   logic                  hit_in_line_ff, hit_in_line_in;
   logic                  nul_seen_ff, nul_seen_in;
   logic [CNT_W-1:0]      bytes_in_line_ff, bytes_in_line_in;
   logic [LINE_IDX_W-1:0] line_counter_ff, line_counter_in;
   logic                  hit_so_far_ff, hit_so_far_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_line_hit_ff, rsp_line_hit_in;
   logic [LINE_IDX_W-1:0] rsp_line_index_ff, rsp_line_index_in;
   logic                  rsp_any_hit_ff, rsp_any_hit_in;
   logic                  rsp_final_line_ff, rsp_final_line_in;

   logic [VEC_W-1:0]      eq_v, mask_v, top_v, mv_step;
   logic                  take, line_end, line_hit;

   assign item_ready = !rsp_valid_ff || rsp_bus.ready;
   assign take       = item_valid && item_ready;

   assign eq_v    = item.eq[VEC_W-1:0];
   assign mask_v  = item.mask[VEC_W-1:0];
   assign top_v   = item.top[VEC_W-1:0];
   assign mv_step = ((match_vector_ff << 1) | VEC_W'(1)) & eq_v & mask_v;

   // Match and line update for one request
   always_comb begin
      match_vector_in   = match_vector_ff;
      hit_in_line_in    = hit_in_line_ff;
      nul_seen_in       = nul_seen_ff;
      bytes_in_line_in  = bytes_in_line_ff;
      line_counter_in   = line_counter_ff;
      hit_so_far_in     = hit_so_far_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_bus.ready;
      rsp_line_hit_in   = rsp_line_hit_ff;
      rsp_line_index_in = rsp_line_index_ff;
      rsp_any_hit_in    = rsp_any_hit_ff;
      rsp_final_line_in = rsp_final_line_ff;
      line_end          = 1'b0;
      line_hit          = 1'b0;
      if (take) begin
         if (!nul_seen_ff) begin
            if (item.is_nul) begin
               nul_seen_in = 1'b1;
            end else begin
               match_vector_in = mv_step;
               if ((mv_step & top_v) != '0) begin
                  hit_in_line_in = 1'b1;
               end
            end
         end
         match_vector_in  = match_vector_in & mask_v;
         bytes_in_line_in = bytes_in_line_ff + 1'b1;
         line_end = item.is_newline || item.is_last ||
                    (bytes_in_line_ff == CNT_W'(LINE_BUF - 2));
         if (line_end) begin
            line_hit          = hit_in_line_in || item.empty;
            rsp_valid_in      = 1'b1;
            rsp_line_hit_in   = line_hit;
            rsp_line_index_in = line_counter_ff;
            rsp_any_hit_in    = hit_so_far_ff || line_hit;
            rsp_final_line_in = item.is_last;
            match_vector_in   = '0;
            hit_in_line_in    = 1'b0;
            nul_seen_in       = 1'b0;
            bytes_in_line_in  = '0;
            if (item.is_last) begin
               line_counter_in = '0;
               hit_so_far_in   = 1'b0;
            end else begin
               line_counter_in = line_counter_ff + 1'b1;
               hit_so_far_in   = hit_so_far_ff || line_hit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_vector_ff  <= '0;
         hit_in_line_ff   <= 1'b0;
         nul_seen_ff      <= 1'b0;
         bytes_in_line_ff <= '0;
         line_counter_ff  <= '0;
         hit_so_far_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         match_vector_ff  <= match_vector_in;
         hit_in_line_ff   <= hit_in_line_in;
         nul_seen_ff      <= nul_seen_in;
         bytes_in_line_ff <= bytes_in_line_in;
         line_counter_ff  <= line_counter_in;
         hit_so_far_ff    <= hit_so_far_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_line_hit_ff   <= rsp_line_hit_in;
      rsp_line_index_ff <= rsp_line_index_in;
      rsp_any_hit_ff    <= rsp_any_hit_in;
      rsp_final_line_ff <= rsp_final_line_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.line_hit   = rsp_line_hit_ff;
   assign rsp_bus.line_index = rsp_line_index_ff;
   assign rsp_bus.any_hit    = rsp_any_hit_ff;
   assign rsp_bus.final_line = rsp_final_line_ff;

endmodule
